### hw/rtl/spiaw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spiaw_pkg
// Shared types, constants and saturation helpers for the speed PI regulator.
// ----------------------------------------------------------------------------
package spiaw_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int GAIN_W    = 31;
    localparam int PERIOD_W  = 17;
    localparam int INTEG_W   = 48;
    localparam int PROD_W    = 64;
    localparam int KI_SPLIT  = 16;
    localparam int ACC_W     = PROD_W + KI_SPLIT;
    localparam int T1_W      = PROD_W - FRAC_BITS;
    localparam int SAT_W     = ACC_W + 1;
    localparam int MUL_W     = DATA_W + 1;
    localparam int IDX_W     = 3;
    localparam int TDATA_W   = 3 * DATA_W;

    typedef enum logic [IDX_W-1:0] {
        REG_ENABLE        = 3'd0,
        REG_PROP_GAIN     = 3'd1,
        REG_INTEG_GAIN    = 3'd2,
        REG_INV_PROP_GAIN = 3'd3,
        REG_SAMPLE_PERIOD = 3'd4,
        REG_SPEED_LIMIT   = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic                enable;
        logic [GAIN_W-1:0]   prop_gain;
        logic [GAIN_W-1:0]   integ_gain;
        logic [GAIN_W-1:0]   inv_prop_gain;
        logic [PERIOD_W-1:0] sample_period;
        logic [GAIN_W-1:0]   speed_limit;
        logic                integ_clear;
    } cfg_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_DIS,
        DP_ERR,
        DP_IIN,
        DP_INTEG,
        DP_T1,
        DP_KIH,
        DP_KIL,
        DP_CMD,
        DP_OUT
    } dp_step_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_FB,
        MUL_INC,
        MUL_KP,
        MUL_KIH,
        MUL_KIL
    } mul_sel_t;

    typedef struct packed {
        dp_step_t step;
        mul_sel_t mul_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    localparam logic signed [SAT_W-1:0] S32_MAX_W = SAT_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [SAT_W-1:0] S32_MIN_W = SAT_W'(-64'sh0000_0000_8000_0000);
    localparam logic signed [SAT_W-1:0] S48_MAX_W = SAT_W'(64'sh0000_7FFF_FFFF_FFFF);
    localparam logic signed [SAT_W-1:0] S48_MIN_W = SAT_W'(-64'sh0000_8000_0000_0000);

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
        logic signed [DATA_W-1:0] r;
        if (x > S32_MAX_W) begin
            r = S32_MAX_W[DATA_W-1:0];
        end else if (x < S32_MIN_W) begin
            r = S32_MIN_W[DATA_W-1:0];
        end else begin
            r = x[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [INTEG_W-1:0] sat48(input logic signed [SAT_W-1:0] x);
        logic signed [INTEG_W-1:0] r;
        if (x > S48_MAX_W) begin
            r = S48_MAX_W[INTEG_W-1:0];
        end else if (x < S48_MIN_W) begin
            r = S48_MIN_W[INTEG_W-1:0];
        end else begin
            r = x[INTEG_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/spiaw_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spiaw_cfg_regs
// Configuration register file; a write to enable also pulses integrator clear.
// ----------------------------------------------------------------------------
module spiaw_cfg_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [spiaw_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [spiaw_pkg::DATA_W-1:0] cfg_data,
    output spiaw_pkg::cfg_t                   cfg
);

    spiaw_pkg::cfg_t cfg_reg;
    spiaw_pkg::cfg_t cfg_next;
    logic            wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid & cfg_ready;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next             = cfg_reg;
        cfg_next.integ_clear = 1'b0;
        if (wr) begin
            case (spiaw_pkg::reg_idx_t'(cfg_index))
                spiaw_pkg::REG_ENABLE: begin
                    cfg_next.enable      = cfg_data[0];
                    cfg_next.integ_clear = 1'b1;
                end
                spiaw_pkg::REG_PROP_GAIN: begin
                    cfg_next.prop_gain = cfg_data[spiaw_pkg::GAIN_W-1:0];
                end
                spiaw_pkg::REG_INTEG_GAIN: begin
                    cfg_next.integ_gain = cfg_data[spiaw_pkg::GAIN_W-1:0];
                end
                spiaw_pkg::REG_INV_PROP_GAIN: begin
                    cfg_next.inv_prop_gain = cfg_data[spiaw_pkg::GAIN_W-1:0];
                end
                spiaw_pkg::REG_SAMPLE_PERIOD: begin
                    cfg_next.sample_period = cfg_data[spiaw_pkg::PERIOD_W-1:0];
                end
                spiaw_pkg::REG_SPEED_LIMIT: begin
                    cfg_next.speed_limit = cfg_data[spiaw_pkg::GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable        <= 1'b0;
            cfg_reg.prop_gain     <= '0;
            cfg_reg.integ_gain    <= '0;
            cfg_reg.inv_prop_gain <= '0;
            cfg_reg.sample_period <= '0;
            cfg_reg.speed_limit   <= '1;
            cfg_reg.integ_clear   <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

`ifndef ASSERT_OFF
    a_clear_on_enable_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr && cfg_index == spiaw_pkg::REG_ENABLE) |=> (cfg_reg.integ_clear
            && cfg_reg.enable == $past(cfg_data[0])))
        else $error("enable write did not clear integrator");
    a_clear_only_on_enable: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr && cfg_index == spiaw_pkg::REG_ENABLE) |=> !cfg_reg.integ_clear)
        else $error("spurious integrator clear");
    a_limit_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr && cfg_index == spiaw_pkg::REG_SPEED_LIMIT) |=> $stable(cfg_reg.speed_limit))
        else $error("speed limit changed without write");
`endif

endmodule
`default_nettype wire

### hw/rtl/spiaw_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spiaw_ctrl
// Sequencer: steps the datapath through one control sample per request.
// ----------------------------------------------------------------------------
module spiaw_ctrl (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic                    enable,
    input  wire spiaw_pkg::dp_status_t   status,
    output spiaw_pkg::dp_cmd_t           cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIS,
        ST_ERR,
        ST_IIN,
        ST_MINC,
        ST_INTEG,
        ST_T1,
        ST_KIH,
        ST_KIL,
        ST_CMD,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;

    always_comb begin
        state_next  = state_reg;
        cmd.step    = spiaw_pkg::DP_NOP;
        cmd.mul_sel = spiaw_pkg::MUL_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.step   = spiaw_pkg::DP_LOAD;
                    state_next = enable ? ST_ERR : ST_DIS;
                end
            end
            ST_DIS: begin
                cmd.step   = spiaw_pkg::DP_DIS;
                state_next = ST_DONE;
            end
            ST_ERR: begin
                cmd.step    = spiaw_pkg::DP_ERR;
                cmd.mul_sel = spiaw_pkg::MUL_FB;
                state_next  = ST_IIN;
            end
            ST_IIN: begin
                cmd.step   = spiaw_pkg::DP_IIN;
                state_next = ST_MINC;
            end
            ST_MINC: begin
                cmd.mul_sel = spiaw_pkg::MUL_INC;
                state_next  = ST_INTEG;
            end
            ST_INTEG: begin
                cmd.step    = spiaw_pkg::DP_INTEG;
                cmd.mul_sel = spiaw_pkg::MUL_KP;
                state_next  = ST_T1;
            end
            ST_T1: begin
                cmd.step    = spiaw_pkg::DP_T1;
                cmd.mul_sel = spiaw_pkg::MUL_KIH;
                state_next  = ST_KIH;
            end
            ST_KIH: begin
                cmd.step    = spiaw_pkg::DP_KIH;
                cmd.mul_sel = spiaw_pkg::MUL_KIL;
                state_next  = ST_KIL;
            end
            ST_KIL: begin
                cmd.step   = spiaw_pkg::DP_KIL;
                state_next = ST_CMD;
            end
            ST_CMD: begin
                cmd.step   = spiaw_pkg::DP_CMD;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.step   = spiaw_pkg::DP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("still ready after accepting a request");
    a_done_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !status.out_free) |=> state_reg == ST_DONE)
        else $error("result dropped while output busy");
    a_out_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step == spiaw_pkg::DP_OUT) |-> status.out_free)
        else $error("output loaded while occupied");
`endif

endmodule
`default_nettype wire

### hw/rtl/spiaw_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spiaw_datapath
// Error, anti-windup feedback, trapezoidal integrator and PI sum around one
// shared registered multiplier; result output register.
// ----------------------------------------------------------------------------
module spiaw_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire spiaw_pkg::cfg_t               cfg,
    input  wire spiaw_pkg::dp_cmd_t            cmd,
    output spiaw_pkg::dp_status_t              status,
    input  wire logic [spiaw_pkg::TDATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [spiaw_pkg::TDATA_W-1:0]      m_tdata
);

    localparam int DW = spiaw_pkg::DATA_W;
    localparam int FB = spiaw_pkg::FRAC_BITS;

    logic signed [DW-1:0]                  ref_reg, ref_next;
    logic signed [DW-1:0]                  meas_reg, meas_next;
    logic signed [DW-1:0]                  clerr_reg, clerr_next;
    logic signed [DW-1:0]                  err_reg, err_next;
    logic signed [DW-1:0]                  iin_reg, iin_next;
    logic signed [DW-1:0]                  prev_reg, prev_next;
    logic signed [spiaw_pkg::INTEG_W-1:0]  integ_reg, integ_next;
    logic signed [spiaw_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic signed [spiaw_pkg::T1_W-1:0]     t1_reg, t1_next;
    logic signed [spiaw_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic signed [DW-1:0]                  held_cmd_reg, held_cmd_next;
    logic signed [DW-1:0]                  held_err_reg, held_err_next;
    logic signed [DW-1:0]                  held_lim_reg, held_lim_next;
    logic [spiaw_pkg::TDATA_W-1:0]         out_data_reg, out_data_next;
    logic                                  out_valid_reg, out_valid_next;

    logic signed [DW-1:0]                  lim_pos, lim_neg, ref_clamped;
    logic signed [DW:0]                    err_diff;
    logic signed [spiaw_pkg::MUL_W-1:0]    mul_a, mul_b, inc_sum;
    logic signed [2*spiaw_pkg::MUL_W-1:0]  mul_full;

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;

    assign lim_pos     = $signed({1'b0, cfg.speed_limit});
    assign lim_neg     = -lim_pos;
    assign ref_clamped = (ref_reg > lim_pos) ? lim_pos :
                         (ref_reg < lim_neg) ? lim_neg : ref_reg;
    assign err_diff    = (DW+1)'(ref_clamped) - (DW+1)'(meas_reg);
    assign inc_sum     = spiaw_pkg::MUL_W'(iin_reg) + spiaw_pkg::MUL_W'(prev_reg);

    // shared multiplier, signed x zero-extended gain
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            spiaw_pkg::MUL_FB: begin
                mul_a = spiaw_pkg::MUL_W'(clerr_reg);
                mul_b = $signed(spiaw_pkg::MUL_W'(cfg.inv_prop_gain));
            end
            spiaw_pkg::MUL_INC: begin
                mul_a = inc_sum;
                mul_b = $signed(spiaw_pkg::MUL_W'(cfg.sample_period));
            end
            spiaw_pkg::MUL_KP: begin
                mul_a = spiaw_pkg::MUL_W'(err_reg);
                mul_b = $signed(spiaw_pkg::MUL_W'(cfg.prop_gain));
            end
            spiaw_pkg::MUL_KIH: begin
                mul_a = spiaw_pkg::MUL_W'(
                    $signed(integ_reg[spiaw_pkg::INTEG_W-1:spiaw_pkg::KI_SPLIT]));
                mul_b = $signed(spiaw_pkg::MUL_W'(cfg.integ_gain));
            end
            spiaw_pkg::MUL_KIL: begin
                mul_a = $signed(spiaw_pkg::MUL_W'(integ_reg[spiaw_pkg::KI_SPLIT-1:0]));
                mul_b = $signed(spiaw_pkg::MUL_W'(cfg.integ_gain));
            end
            default: begin
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    always_comb begin
        ref_next       = ref_reg;
        meas_next      = meas_reg;
        clerr_next     = clerr_reg;
        err_next       = err_reg;
        iin_next       = iin_reg;
        prev_next      = prev_reg;
        integ_next     = integ_reg;
        t1_next        = t1_reg;
        acc_next       = acc_reg;
        held_cmd_next  = held_cmd_reg;
        held_err_next  = held_err_reg;
        held_lim_next  = held_lim_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        prod_next      = (cmd.mul_sel == spiaw_pkg::MUL_NONE) ? prod_reg :
                         mul_full[spiaw_pkg::PROD_W-1:0];
        case (cmd.step)
            spiaw_pkg::DP_LOAD: begin
                ref_next   = $signed(s_tdata[DW-1:0]);
                meas_next  = $signed(s_tdata[2*DW-1:DW]);
                clerr_next = $signed(s_tdata[3*DW-1:2*DW]);
            end
            spiaw_pkg::DP_DIS: begin
                held_lim_next = ref_reg;
            end
            spiaw_pkg::DP_ERR: begin
                err_next = spiaw_pkg::sat32(spiaw_pkg::SAT_W'(err_diff));
            end
            spiaw_pkg::DP_IIN: begin
                iin_next = spiaw_pkg::sat32(spiaw_pkg::SAT_W'(err_reg)
                           - spiaw_pkg::SAT_W'(prod_reg >>> FB));
            end
            spiaw_pkg::DP_INTEG: begin
                integ_next = spiaw_pkg::sat48(spiaw_pkg::SAT_W'(integ_reg)
                             + spiaw_pkg::SAT_W'(prod_reg >>> (FB + 1)));
                prev_next  = iin_reg;
            end
            spiaw_pkg::DP_T1: begin
                t1_next = spiaw_pkg::T1_W'(prod_reg >>> FB);
            end
            spiaw_pkg::DP_KIH: begin
                acc_next = spiaw_pkg::ACC_W'(prod_reg) <<< spiaw_pkg::KI_SPLIT;
            end
            spiaw_pkg::DP_KIL: begin
                acc_next = acc_reg + spiaw_pkg::ACC_W'(prod_reg);
            end
            spiaw_pkg::DP_CMD: begin
                held_cmd_next = spiaw_pkg::sat32(spiaw_pkg::SAT_W'(t1_reg)
                                + spiaw_pkg::SAT_W'(acc_reg >>> FB));
                held_err_next = err_reg;
            end
            spiaw_pkg::DP_OUT: begin
                out_data_next  = {held_lim_reg, held_err_reg, held_cmd_reg};
                out_valid_next = 1'b1;
            end
            default: begin
            end
        endcase
        if (cfg.integ_clear) begin
            integ_next = '0;
            prev_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            integ_reg     <= '0;
            prev_reg      <= '0;
            held_cmd_reg  <= '0;
            held_err_reg  <= '0;
            held_lim_reg  <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            integ_reg     <= integ_next;
            prev_reg      <= prev_next;
            held_cmd_reg  <= held_cmd_next;
            held_err_reg  <= held_err_next;
            held_lim_reg  <= held_lim_next;
        end
    end

    always_ff @(posedge aclk) begin
        ref_reg      <= ref_next;
        meas_reg     <= meas_next;
        clerr_reg    <= clerr_next;
        err_reg      <= err_next;
        iin_reg      <= iin_next;
        prod_reg     <= prod_next;
        t1_reg       <= t1_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

`ifndef ASSERT_OFF
    a_integ_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg.integ_clear |=> (integ_reg == '0 && prev_reg == '0))
        else $error("integrator not cleared");
    a_cmd_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step != spiaw_pkg::DP_CMD) |=> $stable(held_cmd_reg))
        else $error("current command changed outside its step");
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while waiting");
`endif

endmodule
`default_nettype wire

### hw/rtl/speed_pi_controller_antiwindup_core.sv
// Sequence: enabled, a request steps through error, integrator input, integrator and PI
//   sum, with a single shared multiplier for five products; disabled, it skips to output.
//   A new request is taken only once the result is loaded into the output register.
// Reset: aresetn synchronous, active low; clears config to defaults, integrator,
//   held outputs and output valid. No clearing pass.
// ----------------------------------------------------------------------------
// speed_pi_controller_antiwindup_core
// Speed-loop PI regulator with back-calculation anti-windup, Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none
module speed_pi_controller_antiwindup_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // speed_ref [31:0], speed_meas [63:32], current_limit_err [95:64]
    input  wire logic [spiaw_pkg::TDATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // current_cmd [31:0], speed_err [63:32], speed_limit_err [95:64]
    output logic [spiaw_pkg::TDATA_W-1:0]      m_tdata,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [spiaw_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [spiaw_pkg::DATA_W-1:0]  cfg_data
);

    spiaw_pkg::cfg_t       cfg;
    spiaw_pkg::dp_cmd_t    cmd;
    spiaw_pkg::dp_status_t status;

    spiaw_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    spiaw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .enable   (cfg.enable),
        .status   (status),
        .cmd      (cmd)
    );

    spiaw_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

### tb/sv/spiaw_regulator_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spiaw_regulator_check
// Watches the sample, result and register channels of the speed PI regulator.
// Keeps its own copy of the registers and the integrator, predicts every
// result from the accepted requests, and compares each result field by field.
// ----------------------------------------------------------------------------
module spiaw_regulator_check
    import spiaw_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [TDATA_W-1:0]   m_tdata,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    output int                   fail_count,
    output int                   pending,
    output int                   checked
);

    typedef struct packed {
        logic signed [DATA_W-1:0] current_limit_err;
        logic signed [DATA_W-1:0] speed_meas;
        logic signed [DATA_W-1:0] speed_ref;
    } pi_sample_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] speed_limit_err;
        logic signed [DATA_W-1:0] speed_err;
        logic signed [DATA_W-1:0] current_cmd;
    } pi_result_t;

    localparam longint S32_HI   = 64'sh0000_0000_7FFF_FFFF;
    localparam longint S32_LO   = -64'sh0000_0000_8000_0000;
    localparam longint S48_HI   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint S48_LO   = -64'sh0000_8000_0000_0000;
    localparam longint KI_CLAMP = 64'sh1000_0000_0000_0000;

    // register copy
    logic                run_en;
    logic [GAIN_W-1:0]   kp;
    logic [GAIN_W-1:0]   ki;
    logic [GAIN_W-1:0]   inv_kp;
    logic [PERIOD_W-1:0] t_sample;
    logic [GAIN_W-1:0]   spd_lim;

    // regulator state
    logic signed [INTEG_W-1:0] integ_acc;
    logic signed [DATA_W-1:0]  prev_iin;
    logic signed [DATA_W-1:0]  held_cmd;
    logic signed [DATA_W-1:0]  held_err;
    logic signed [DATA_W-1:0]  held_lim;

    pi_result_t predicted_outputs[$];
    pi_result_t want;
    pi_result_t got;

    function automatic longint clamp(input longint x, input longint lo, input longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function automatic pi_result_t run_pi_sample(input pi_sample_t smp);
        longint ref_v, meas_v, clerr_v, lim_v, kp_v, ki_v, inv_v, per_v;
        longint err, fb, iin, inc, acc, t1, hi, lo, mag, prod, t2;
        pi_result_t res;
        ref_v   = smp.speed_ref;
        meas_v  = smp.speed_meas;
        clerr_v = smp.current_limit_err;
        if (!run_en) begin
            held_lim = smp.speed_ref;
        end else begin
            lim_v = spd_lim;
            kp_v  = kp;
            ki_v  = ki;
            inv_v = inv_kp;
            per_v = t_sample;
            err = clamp(clamp(ref_v, -lim_v, lim_v) - meas_v, S32_LO, S32_HI);
            fb  = (clerr_v * inv_v) >>> FRAC_BITS;
            iin = clamp(err - fb, S32_LO, S32_HI);
            inc = ((iin + prev_iin) * per_v) >>> (FRAC_BITS + 1);
            acc = clamp(integ_acc + inc, S48_LO, S48_HI);
            integ_acc = acc;
            prev_iin  = iin;
            t1  = (err * kp_v) >>> FRAC_BITS;
            hi  = acc >>> FRAC_BITS;
            lo  = acc - (hi <<< FRAC_BITS);
            mag = (hi < 0) ? -hi : hi;
            if (ki_v != 0 && mag > KI_CLAMP / ki_v) begin
                prod = (hi < 0) ? -KI_CLAMP : KI_CLAMP;
            end else begin
                prod = hi * ki_v;
            end
            t2 = prod + ((lo * ki_v) >>> FRAC_BITS);
            held_cmd = clamp(t1 + t2, S32_LO, S32_HI);
            held_err = err;
        end
        res.current_cmd     = held_cmd;
        res.speed_err       = held_err;
        res.speed_limit_err = held_lim;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH %s", $time, what);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            run_en    = 1'b0;
            kp        = '0;
            ki        = '0;
            inv_kp    = '0;
            t_sample  = '0;
            spd_lim   = {GAIN_W{1'b1}};
            integ_acc = '0;
            prev_iin  = '0;
            held_cmd  = '0;
            held_err  = '0;
            held_lim  = '0;
            predicted_outputs.delete();
            fail_count = 0;
            checked    = 0;
            pending   <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ENABLE: begin
                        run_en    = cfg_data[0];
                        integ_acc = '0;
                        prev_iin  = '0;
                    end
                    REG_PROP_GAIN:     kp       = cfg_data[GAIN_W-1:0];
                    REG_INTEG_GAIN:    ki       = cfg_data[GAIN_W-1:0];
                    REG_INV_PROP_GAIN: inv_kp   = cfg_data[GAIN_W-1:0];
                    REG_SAMPLE_PERIOD: t_sample = cfg_data[PERIOD_W-1:0];
                    REG_SPEED_LIMIT:   spd_lim  = cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (predicted_outputs.size() == 0) begin
                    report_mismatch($sformatf("unrequested result %h", m_tdata));
                end else begin
                    want = predicted_outputs.pop_front();
                    checked++;
                    if (got.current_cmd !== want.current_cmd)
                        report_mismatch($sformatf("current_cmd got %h want %h",
                                                  got.current_cmd, want.current_cmd));
                    if (got.speed_err !== want.speed_err)
                        report_mismatch($sformatf("speed_err got %h want %h",
                                                  got.speed_err, want.speed_err));
                    if (got.speed_limit_err !== want.speed_limit_err)
                        report_mismatch($sformatf("speed_limit_err got %h want %h",
                                                  got.speed_limit_err, want.speed_limit_err));
                end
            end
            if (s_tvalid && s_tready)
                predicted_outputs.push_back(run_pi_sample(s_tdata));
            pending <= predicted_outputs.size();
        end
    end

endmodule

### tb/sv/tb_speed_pi_controller_antiwindup_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_speed_pi_controller_antiwindup_core
// Stimulus and verdict for the speed PI regulator: directed corner samples,
// integrator driven hard in both directions, then randomized register settings
// and samples with random stalls on both streams. Checking is done by
// spiaw_regulator_check.
// ----------------------------------------------------------------------------
module tb_speed_pi_controller_antiwindup_core;
    import spiaw_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE       = 16;
    localparam int WINDUP_ITEMS = 40;
    localparam int NUM_PHASES   = 10;
    localparam int PHASE_ITEMS  = 65;

    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [DATA_W-1:0] S_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] S_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] ONE   = 32'h0001_0000;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata   = '0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [DATA_W-1:0]  cfg_data  = '0;

    int fail_count;
    int pending;
    int checked;
    int n_samples = 0;
    int n_writes  = 0;
    int stall_cycles = 0;
    bit quiet = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    speed_pi_controller_antiwindup_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    spiaw_regulator_check u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    always @(posedge aclk) begin
        m_tready <= quiet || ($urandom_range(0, 99) >= 10);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[%0t] watchdog: no handshake for %0d cycles, %0d results owed",
                         $time, stall_cycles, pending);
                $display("speed_pi_controller_antiwindup_core verification failed");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        n_writes++;
        @(posedge aclk);
    endtask

    task automatic send_sample(input logic [DATA_W-1:0] spd_ref, input logic [DATA_W-1:0] spd_meas,
                               input logic [DATA_W-1:0] clerr);
        while (!quiet && $urandom_range(0, 99) < 10) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {clerr, spd_meas, spd_ref};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_samples++;
    endtask

    // all results back, then let the pipeline settle before touching registers
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [DATA_W-1:0] pick_speed();
        case ($urandom_range(0, 9))
            0:       return S_MIN;
            1:       return S_MAX;
            2, 3:    return $urandom;
            default: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_setting(input logic [IDX_W-1:0] idx);
        logic [DATA_W-1:0] v;
        v = $urandom;
        if (idx == REG_ENABLE) begin
            v[0] = ($urandom_range(0, 99) < 80);
        end else begin
            case ($urandom_range(0, 5))
                0: v = '0;
                1: v = '1;
                2: ;
                default: begin
                    case (idx)
                        REG_SAMPLE_PERIOD: v = $urandom_range(0, 32'h0000_1000);
                        REG_SPEED_LIMIT:   v = $urandom_range(0, 32'h0100_0000);
                        default:           v = $urandom_range(0, 32'h0004_0000);
                    endcase
                end
            endcase
        end
        return v;
    endfunction

    initial begin
        int ph;
        int r;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // disabled after reset: reference echoed, rest held at zero
        send_sample(S_MIN, ONE, S_MAX);
        send_sample(S_MAX, S_MIN, S_MIN);
        wait_idle();

        write_reg(REG_PROP_GAIN, ONE);
        write_reg(REG_INTEG_GAIN, 32'h0000_8000);
        write_reg(REG_INV_PROP_GAIN, ONE);
        write_reg(REG_SAMPLE_PERIOD, 32'h0000_0CCD);
        write_reg(REG_ENABLE, 32'h0000_0001);
        send_sample(32'h0, 32'h0, 32'h0);
        send_sample(S_MAX, S_MIN, 32'h0);
        send_sample(S_MIN, S_MAX, 32'h0);
        send_sample(32'h0001_8000, 32'h0000_8000, 32'h0000_4000);
        send_sample(32'h0, 32'h0, S_MIN);
        send_sample(S_MIN, 32'h0, S_MAX);
        send_sample(32'h0, 32'h0, S_MAX);
        send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_idle();

        // reference clamp and command saturation
        write_reg(REG_SPEED_LIMIT, 32'h0002_0000);
        write_reg(REG_PROP_GAIN, 32'h7FFF_FFFF);
        send_sample(S_MAX, 32'h0, 32'h0);
        send_sample(S_MIN, 32'h0, 32'h0);
        send_sample(32'h0001_8000, S_MIN, 32'h0);
        wait_idle();
        write_reg(REG_SPEED_LIMIT, 32'h0);
        send_sample(S_MAX, ONE, 32'h0);
        wait_idle();

        write_reg(REG_ENABLE, 32'h0);
        send_sample(32'h1234_5678, S_MAX, S_MIN);
        send_sample(S_MIN, 32'h0, 32'h0);
        wait_idle();

        // period above one second, zero Ki
        write_reg(REG_SAMPLE_PERIOD, 32'hFFFF_FFFF);
        write_reg(REG_INTEG_GAIN, 32'h0);
        write_reg(REG_SPEED_LIMIT, 32'h7FFF_FFFF);
        write_reg(REG_ENABLE, 32'h0000_0001);
        send_sample(ONE, 32'h0, 32'h0);
        send_sample(S_MIN, ONE, ONE);
        wait_idle();
        write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_HI, 32'h0);
        send_sample(32'h0002_0000, 32'hFFFF_0000, 32'h0);
        wait_idle();

        // integrator driven hard, positive then negative
        write_reg(REG_INTEG_GAIN, 32'h7FFF_FFFF);
        write_reg(REG_INV_PROP_GAIN, 32'h7FFF_FFFF);
        write_reg(REG_SAMPLE_PERIOD, 32'h0001_FFFF);
        write_reg(REG_PROP_GAIN, 32'h0000_0100);
        write_reg(REG_ENABLE, 32'h0000_0001);
        quiet = 1'b1;
        repeat (WINDUP_ITEMS) send_sample($urandom, $urandom, S_MIN);
        wait_idle();
        write_reg(REG_ENABLE, 32'h0000_0001);
        repeat (WINDUP_ITEMS) send_sample($urandom, $urandom, S_MAX);
        wait_idle();
        quiet = 1'b0;

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            for (r = REG_ENABLE; r <= REG_SPEED_LIMIT; r++) begin
                if (ph == 0 || $urandom_range(0, 99) < 60)
                    write_reg(r[IDX_W-1:0], pick_setting(r[IDX_W-1:0]));
            end
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
            quiet = (ph == 6 || ph == 7);
            repeat (PHASE_ITEMS)
                send_sample(pick_speed(), pick_speed(),
                            $urandom_range(0, 1) ? 32'h0 : pick_speed());
        end
        quiet = 1'b0;
        wait_idle();

        $display("Run: %0d samples, %0d register writes, %0d results compared",
                 n_samples, n_writes, checked);
        $display("Covered corner samples, integrator driven hard both ways, %0d random settings",
                 NUM_PHASES);
        if (fail_count == 0) begin
            $display("speed_pi_controller_antiwindup_core verification clean");
        end else begin
            $display("speed_pi_controller_antiwindup_core verification failed");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/spiaw_pkg.sv
hw/rtl/spiaw_cfg_regs.sv
hw/rtl/spiaw_ctrl.sv
hw/rtl/spiaw_datapath.sv
hw/rtl/speed_pi_controller_antiwindup_core.sv
tb/sv/spiaw_regulator_check.sv
tb/sv/tb_speed_pi_controller_antiwindup_core.sv
